// ----- hw/rtl/pptw_pkg.sv -----
`default_nettype none

package pptw_pkg;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_EASING   = 2'd0,
		REG_START    = 2'd1,
		REG_END      = 2'd2,
		REG_DURATION = 2'd3
	} reg_idx_t;

	// Easing curve codes; the spare code runs as linear
	typedef enum logic [1:0] {
		EASE_LINEAR = 2'd0,
		EASE_IN     = 2'd1,
		EASE_OUT    = 2'd2,
		EASE_SPARE  = 2'd3
	} ease_mode_t;

	localparam int unsigned CFG_ADDR_W  = 5;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned TIME_W      = 64;
	localparam int unsigned COLOR_W     = 32;
	localparam int unsigned CHAN_W      = 8;
	localparam int unsigned NUM_CHAN    = 4;

endpackage

`default_nettype wire

// ----- hw/rtl/pptw_div_cell.sv -----
`default_nettype none

// One restoring division step: shift in the next dividend bit, subtract
// the divisor where it fits and shift the quotient bit in at the bottom.
module pptw_div_cell #(
	parameter int unsigned W  = 41,
	parameter int unsigned DW = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vld_in,
	input  wire logic [W-1:0]  rem_in,
	input  wire logic [DW-1:0] dat_in,
	input  wire logic [W-1:0]  den,
	output logic               vld_q,
	output logic [W-1:0]       rem_q,
	output logic [DW-1:0]      dat_q
);

	logic [W:0]  sh;
	logic [W:0]  diff;
	logic        ge;

	// Trial subtract
	always_comb begin
		sh   = {rem_in, dat_in[DW-1]};
		diff = sh - {1'b0, den};
		ge   = (sh >= {1'b0, den});
	end

	// Hold the valid flag under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	// Advance partial remainder and quotient
	always_ff @(posedge clk) begin
		rem_q <= ge ? diff[W-1:0] : sh[W-1:0];
		dat_q <= {dat_in[DW-2:0], ge};
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ping_pong_color_tween_core.sv -----
`default_nettype none

// Ping-pong RGBA colour tween.
// Configure over the APB port: easing mode at 0x00, start colour at 0x08,
// end colour at 0x10, one-way duration in ns at 0x18 (64-bit data bus,
// pready always high). Write registers only while no transfer is in flight.
// Issue a time by raising start with time_now; busy stays low, so a new
// time may be issued in every cycle. Each time gives one colour on
// color_out, marked by done for one cycle. Throughput is one colour per
// cycle. The pipeline is a chain of division cells: 64 cells reduce the
// time modulo twice the duration, one bit per cell, a fold stage mirrors
// the second half back, FRAC_BITS cells form the fraction, and easing and
// blend stages follow. The sink cannot stall; done is a strobe and must
// be taken. Reset clears the configuration registers and valid flags and
// so empties the pipeline; a zero duration gives the end colour.
module ping_pong_color_tween_core #(
	parameter int unsigned FRAC_BITS     = 16,
	parameter int unsigned DURATION_BITS = 40
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [pptw_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [pptw_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic      [pptw_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                    pready,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [pptw_pkg::TIME_W-1:0]        time_now,
	output logic                                    done,
	output logic      [pptw_pkg::COLOR_W-1:0]       color_out
);

	localparam int unsigned F   = FRAC_BITS;
	localparam int unsigned DB  = DURATION_BITS;
	localparam int unsigned PW  = DB + 1;
	localparam int unsigned TW  = pptw_pkg::TIME_W;
	localparam int unsigned CW  = pptw_pkg::CHAN_W;
	localparam int unsigned LAT = TW + F + 3;

	localparam logic [F:0]   ONE_Q     = {1'b1, {F{1'b0}}};
	localparam logic [F+1:0] TWO_ONE_Q = {1'b1, {(F+1){1'b0}}};

	// ---------------- configuration registers ----------------
	logic [1:0]                    easing_q;
	logic [pptw_pkg::COLOR_W-1:0]  start_q;
	logic [pptw_pkg::COLOR_W-1:0]  end_q;
	logic [DB-1:0]                 dur_q;
	logic                          cfg_wr;
	pptw_pkg::reg_idx_t            cfg_idx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = pptw_pkg::reg_idx_t'(paddr[4:3]);

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			easing_q <= '0;
			start_q  <= '0;
			end_q    <= '0;
			dur_q    <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				pptw_pkg::REG_EASING:   easing_q <= pwdata[1:0];
				pptw_pkg::REG_START:    start_q  <= pwdata[31:0];
				pptw_pkg::REG_END:      end_q    <= pwdata[31:0];
				pptw_pkg::REG_DURATION: dur_q    <= pwdata[DB-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (cfg_idx)
			pptw_pkg::REG_EASING:   prdata = 64'(easing_q);
			pptw_pkg::REG_START:    prdata = 64'(start_q);
			pptw_pkg::REG_END:      prdata = 64'(end_q);
			pptw_pkg::REG_DURATION: prdata = 64'(dur_q);
			default:                prdata = '0;
		endcase
	end

	// ---------------- modulo chain: time mod (2 * duration) ----------------
	logic [PW-1:0] period;
	logic          mod_vld [0:TW];
	logic [PW-1:0] mod_rem [0:TW];
	logic [TW-1:0] mod_dat [0:TW];

	assign period     = {dur_q, 1'b0};
	assign mod_vld[0] = start;
	assign mod_rem[0] = '0;
	assign mod_dat[0] = time_now;

	for (genvar g = 0; g < TW; g++) begin : g_mod
		pptw_div_cell #(.W(PW), .DW(TW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (mod_vld[g]),
			.rem_in (mod_rem[g]),
			.dat_in (mod_dat[g]),
			.den    (period),
			.vld_q  (mod_vld[g+1]),
			.rem_q  (mod_rem[g+1]),
			.dat_q  (mod_dat[g+1])
		);
	end

	// ---------------- fold stage ----------------
	logic [PW-1:0] fold_pos;
	logic          fold_half;
	logic          fold_vld_s1;
	logic [DB-1:0] fold_rem_s1;
	logic          fold_half_s1;

	// Mirror the second half back
	always_comb begin
		fold_pos  = (mod_rem[TW] > {1'b0, dur_q}) ? (period - mod_rem[TW]) : mod_rem[TW];
		fold_half = (fold_pos == {1'b0, dur_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_vld_s1 <= 1'b0;
		end else begin
			fold_vld_s1 <= mod_vld[TW];
		end
	end

	always_ff @(posedge clk) begin
		fold_half_s1 <= fold_half;
		fold_rem_s1  <= fold_half ? '0 : fold_pos[DB-1:0];
	end

	// ---------------- fraction chain: pos * ONE / duration ----------------
	logic          frac_vld  [0:F];
	logic [DB-1:0] frac_rem  [0:F];
	logic [F-1:0]  frac_dat  [0:F];
	logic          frac_half_q [0:F];

	assign frac_vld[0]    = fold_vld_s1;
	assign frac_rem[0]    = fold_rem_s1;
	assign frac_dat[0]    = '0;
	assign frac_half_q[0] = fold_half_s1;

	for (genvar g = 0; g < F; g++) begin : g_frac
		pptw_div_cell #(.W(DB), .DW(F)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (frac_vld[g]),
			.rem_in (frac_rem[g]),
			.dat_in (frac_dat[g]),
			.den    (dur_q),
			.vld_q  (frac_vld[g+1]),
			.rem_q  (frac_rem[g+1]),
			.dat_q  (frac_dat[g+1])
		);

		// Carry the whole-unit bit beside the cell
		always_ff @(posedge clk) begin
			frac_half_q[g+1] <= frac_half_q[g];
		end
	end

	// ---------------- easing stage ----------------
	logic [F:0]     t_frac;
	logic [F+1:0]   t_rest;
	logic [2*F+2:0] ease_prod;
	logic           ease_vld_s2;
	logic [F:0]     ease_c_s2;

	always_comb begin
		t_frac = {frac_half_q[F], frac_dat[F]};
		t_rest = TWO_ONE_Q - {1'b0, t_frac};
		case (pptw_pkg::ease_mode_t'(easing_q))
			pptw_pkg::EASE_IN:  ease_prod = t_frac * t_frac;
			pptw_pkg::EASE_OUT: ease_prod = t_frac * t_rest;
			default:            ease_prod = {t_frac, {F{1'b0}}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ease_vld_s2 <= 1'b0;
		end else begin
			ease_vld_s2 <= frac_vld[F];
		end
	end

	always_ff @(posedge clk) begin
		ease_c_s2 <= ease_prod[2*F:F];
	end

	// ---------------- blend stage ----------------
	logic [F:0]                   inv_c;
	logic [pptw_pkg::COLOR_W-1:0] blend_col;

	// Mix each channel from start to end
	always_comb begin
		logic [F+CW+1:0] acc;
		inv_c     = ONE_Q - ease_c_s2;
		blend_col = '0;
		for (int k = 0; k < pptw_pkg::NUM_CHAN; k++) begin
			acc = start_q[k*CW +: CW] * inv_c + end_q[k*CW +: CW] * ease_c_s2;
			blend_col[k*CW +: CW] = acc[F+CW-1:F];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ease_vld_s2;
		end
	end

	// Zero duration gives the end colour
	always_ff @(posedge clk) begin
		color_out <= (dur_q == '0) ? end_q : blend_col;
	end

`ifndef ASSERT_OFF
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result missing after start");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		ease_vld_s2 |=> done)
		else $error("blend stage result lost");
	a_fold_chain: assert property (@(posedge clk) disable iff (!arst_n)
		mod_vld[TW] |=> fold_vld_s1)
		else $error("fold stage dropped a transfer");
`endif

endmodule

`default_nettype wire

// ----- sim/tween_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tween_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pptw_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [pptw_pkg::CFG_DATA_W-1:0] pwdata,
	input  wire logic                            pready,
	input  wire logic                            start,
	input  wire logic                            busy,
	input  wire logic [pptw_pkg::TIME_W-1:0]     time_now,
	input  wire logic                            done,
	input  wire logic [pptw_pkg::COLOR_W-1:0]    color_out,
	output int unsigned                          fail_count,
	output int unsigned                          colours_pending
);

	localparam int unsigned FRAC  = 16;
	localparam logic [63:0] ONE_Q = 64'd1 << FRAC;

	// Shadow copy of the registers
	pptw_pkg::ease_mode_t  mode_q;
	logic [31:0] start_col_q;
	logic [31:0] end_col_q;
	logic [39:0] dur_q;

	logic [31:0] colour_queue[$];

	function automatic logic [31:0] tween_colour(input logic [63:0] tnow);
		logic [64:0]  period;
		logic [64:0]  pos;
		logic [63:0]  frac;
		logic [63:0]  coef;
		logic [63:0]  s;
		logic [63:0]  e;
		logic [127:0] r;
		logic [127:0] prod;
		logic [31:0]  res;
		if (dur_q == 0) begin
			return end_col_q;
		end
		period = {25'd0, dur_q} * 2;
		pos = {1'b0, tnow} % period;
		if (pos > dur_q) begin
			pos = period - pos;
		end
		// Exact fraction by plain division
		r = {63'd0, pos} << FRAC;
		frac = 64'(r / dur_q);
		case (mode_q)
			pptw_pkg::EASE_IN: begin
				prod = frac * frac;
				coef = 64'(prod >> FRAC);
			end
			pptw_pkg::EASE_OUT: begin
				prod = frac * (2 * ONE_Q - frac);
				coef = 64'(prod >> FRAC);
			end
			default: coef = frac;
		endcase
		res = '0;
		for (int ch = 0; ch < pptw_pkg::NUM_CHAN; ch++) begin
			s = 64'(start_col_q[ch*8 +: 8]);
			e = 64'(end_col_q[ch*8 +: 8]);
			res[ch*8 +: 8] = 8'((s * (ONE_Q - coef) + e * coef) >> FRAC);
		end
		return res;
	endfunction

	assign colours_pending = colour_queue.size();

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			mode_q      <= pptw_pkg::EASE_LINEAR;
			start_col_q <= '0;
			end_col_q   <= '0;
			dur_q       <= '0;
			fail_count  <= 0;
			colour_queue.delete();
		end else begin
			// Compare the result transfer against the oldest prediction
			if (done) begin
				if (colour_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected colour %h at %0t", color_out, $realtime);
					fail_count <= fail_count + 1;
				end else begin
					want = colour_queue.pop_front();
					if (want !== color_out) begin
						if (fail_count < 10)
							$display("colour mismatch: expected %h got %h", want, color_out);
						fail_count <= fail_count + 1;
					end
				end
			end
			// Predict for each accepted time transfer
			if (start && !busy) begin
				colour_queue.push_back(tween_colour(time_now));
			end
			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (pptw_pkg::reg_idx_t'(paddr[4:3]))
					pptw_pkg::REG_EASING:
						mode_q <= pptw_pkg::ease_mode_t'(pwdata[1:0]);
					pptw_pkg::REG_START:    start_col_q <= pwdata[31:0];
					pptw_pkg::REG_END:      end_col_q <= pwdata[31:0];
					pptw_pkg::REG_DURATION: dur_q <= pwdata[39:0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

	localparam int unsigned LAT         = 83;
	localparam int unsigned STALL_LIMIT = 2000;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [pptw_pkg::CFG_ADDR_W-1:0] paddr;
	logic [pptw_pkg::CFG_DATA_W-1:0] pwdata;
	logic [pptw_pkg::CFG_DATA_W-1:0] prdata;
	logic                            pready;
	logic                            start;
	logic                            busy;
	logic [pptw_pkg::TIME_W-1:0]     time_now;
	logic                            done;
	logic [pptw_pkg::COLOR_W-1:0]    color_out;
	int unsigned                     fail_count;
	int unsigned                     colours_pending;
	int unsigned                     quiet_cycles = 0;
	logic [39:0]                     cur_dur;

	ping_pong_color_tween_core dut (.*);

	tween_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("ping_pong_color_tween_core test failed");
			$finish;
		end
	end

	task automatic write_reg(input pptw_pkg::reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= pptw_pkg::CFG_ADDR_W'({idx, 3'b000});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == pptw_pkg::REG_DURATION)
			cur_dur = value[39:0];
	endtask

	// Issue one time, after a random gap when allowed; start stays high across back-to-back items
	task automatic send_time(input logic [63:0] tnow, input bit allow_gap);
		int unsigned gap;
		gap = allow_gap ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start    <= 1'b1;
		time_now <= tnow;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (colours_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Times biased around the fold points of the current duration
	function automatic logic [63:0] pick_time();
		logic [63:0] d;
		d = {24'd0, cur_dur};
		case ($urandom_range(0, 5))
			0: return rand64();
			1: return d * $urandom_range(0, 6) + $urandom_range(0, 3) - 1;
			2: return 64'($urandom_range(0, 1000));
			3: return (rand64() % (2 * d + 1)) + d * 2 * $urandom_range(0, 1000);
			default: return (d == 0) ? rand64() : rand64() % (4 * d);
		endcase
	endfunction

	initial begin
		logic [63:0] d;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		start = 0; time_now = '0; cur_dur = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zero duration at reset, then the fold points
		send_time(64'd0, 0);
		send_time('1, 0);
		drain();
		write_reg(pptw_pkg::REG_START, 32'h00FF_10F0);
		write_reg(pptw_pkg::REG_END, 32'hFF00_F010);
		write_reg(pptw_pkg::REG_DURATION, 64'd1000);
		for (int m = 0; m < 4; m++) begin
			write_reg(pptw_pkg::REG_EASING, 64'(m));
			d = 1000;
			send_time(64'd0, 0);
			send_time(d, 0);
			send_time(d + 1, 0);
			send_time(2 * d - 1, 0);
			send_time(2 * d, 0);
			send_time(d / 2, 0);
			drain();
		end
		write_reg(pptw_pkg::REG_DURATION, 64'hFF_FFFF_FFFF);
		send_time('1, 0);
		send_time(64'hFF_FFFF_FFFF, 0);
		drain();
		write_reg(pptw_pkg::REG_DURATION, 64'd1);
		send_time('1, 0);
		send_time(64'd1, 0);
		drain();
		write_reg(pptw_pkg::REG_START, '1);
		write_reg(pptw_pkg::REG_END, 64'd0);
		send_time(64'd2, 0);
		drain();

		// Random phases over varied settings
		for (int ph = 0; ph < 15; ph++) begin
			write_reg(pptw_pkg::REG_EASING, 64'($urandom_range(0, 3)));
			write_reg(pptw_pkg::REG_START, 64'($urandom));
			write_reg(pptw_pkg::REG_END, 64'($urandom));
			case ($urandom_range(0, 4))
				0: write_reg(pptw_pkg::REG_DURATION, 64'($urandom_range(0, 3)));
				1: write_reg(pptw_pkg::REG_DURATION, 64'hFF_FFFF_FFFF);
				2: write_reg(pptw_pkg::REG_DURATION, 64'($urandom_range(1, 100000)));
				default: write_reg(pptw_pkg::REG_DURATION,
					64'(rand64() & 64'hFF_FFFF_FFFF));
			endcase
			for (int i = 0; i < 28; i++)
				send_time(pick_time(), (ph % 3) != 0);
			drain();
		end

		drain();
		repeat (LAT + 10) @(negedge clk);
		if (fail_count == 0 && colours_pending == 0)
			$display("ping_pong_color_tween_core test passed");
		else
			$display("ping_pong_color_tween_core test failed");
		$finish;
	end

endmodule

`default_nettype wire
